[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tlct_pkg.sv]
// ----------------------------------------------------------------------------
// tlct_pkg
// Types and constants of the timed LED change table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlct_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int TIME_BITS    = 32;
    localparam int PIN_BITS     = 4;
    localparam int SLOT_BITS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMD_DEPTH    = 2;
    localparam int CMD_PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED   = 2'd0,
        KIND_FULL       = 2'd1,
        KIND_PIN_CHANGE = 2'd2,
        KIND_IDLE       = 2'd3
    } t_kind;

    typedef struct packed {
        logic                 op;
        logic [TIME_BITS-1:0] due_time;
        logic [PIN_BITS-1:0]  led_pin;
        logic                 led_on;
        logic [TIME_BITS-1:0] now_time;
    } t_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [PIN_BITS-1:0] out_pin;
        logic                pin_level;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                 is_tick;
        logic                 discard;
        logic [TIME_BITS-1:0] time_val;
        logic [PIN_BITS-1:0]  pin;
        logic                 on;
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/tlct_front.sv]
// ----------------------------------------------------------------------------
// tlct_front
// Accepts input items and classifies them into table commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlct_front (
    input  wire logic            push,
    input  wire tlct_pkg::t_item i_item,
    output logic                 full,
    input  wire logic            i_q_full,
    output logic                 o_q_push,
    output tlct_pkg::t_cmd       o_q_cmd
);
    import tlct_pkg::*;

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    always_comb begin
        o_q_cmd.is_tick  = (i_item.op == OP_TICK);
        o_q_cmd.discard  = (i_item.due_time == '0);
        o_q_cmd.time_val = (i_item.op == OP_TICK) ? i_item.now_time : i_item.due_time;
        o_q_cmd.pin      = i_item.led_pin;
        o_q_cmd.on       = i_item.led_on;
    end

endmodule

`default_nettype wire

[hw/rtl/tlct_cmd_queue.sv]
// ----------------------------------------------------------------------------
// tlct_cmd_queue
// Short command queue between the front and the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlct_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tlct_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tlct_pkg::t_cmd      o_cmd
);
    import tlct_pkg::*;

    t_cmd                    r_mem [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] r_wr_ptr;
    logic [CMD_PTR_BITS-1:0] r_rd_ptr;
    logic [CMD_CNT_BITS-1:0] r_count;
    logic                    wr_en;
    logic                    rd_en;

    assign o_full  = (r_count == CMD_CNT_BITS'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    function automatic logic [CMD_PTR_BITS-1:0] ptr_inc(input logic [CMD_PTR_BITS-1:0] p);
        if (p == CMD_PTR_BITS'(CMD_DEPTH - 1)) begin
            return '0;
        end
        return p + CMD_PTR_BITS'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CMD_CNT_BITS'(1);
                2'b01:   r_count <= r_count - CMD_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tlct_back.sv]
// ----------------------------------------------------------------------------
// tlct_back
// Slot table engine: stores schedules, scans slots on a tick, and holds
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlct_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire tlct_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output tlct_pkg::t_result   o_result
);
    import tlct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [SLOT_COUNT-1:0] r_occ, n_occ;
    logic [TIME_BITS-1:0]  r_due [SLOT_COUNT];
    logic [PIN_BITS-1:0]   r_pin [SLOT_COUNT];
    logic                  r_on  [SLOT_COUNT];
    logic [SLOT_BITS-1:0]  r_idx, n_idx;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic                  r_hold_valid, n_hold_valid;
    logic [PIN_BITS-1:0]   r_hold_pin, n_hold_pin;
    logic                  r_hold_level, n_hold_level;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  out_free;
    logic                  out_load;
    t_result               out_data;
    logic                  free_found;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  fire;
    logic                  advance;
    logic                  wr_en;

    assign empty    = !r_out_valid;
    assign o_result = r_out;
    assign out_free = !r_out_valid || pop;
    assign fire     = r_occ[r_idx] && (r_now > r_due[r_idx]);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_now        = r_now;
        n_hold_valid = r_hold_valid;
        n_hold_pin   = r_hold_pin;
        n_hold_level = r_hold_level;
        o_cmd_pop    = 1'b0;
        wr_en        = 1'b0;
        advance      = 1'b0;
        out_load     = 1'b0;
        out_data     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_tick) begin
                        o_cmd_pop    = 1'b1;
                        n_now        = i_cmd.time_val;
                        n_idx        = '0;
                        n_hold_valid = 1'b0;
                        n_state      = ST_SCAN;
                    end else if (out_free) begin
                        o_cmd_pop     = 1'b1;
                        out_load      = 1'b1;
                        out_data.last = 1'b1;
                        if (free_found) begin
                            out_data.kind = KIND_ACCEPTED;
                            if (!i_cmd.discard) begin
                                wr_en           = 1'b1;
                                n_occ[free_idx] = 1'b1;
                            end
                        end else begin
                            out_data.kind = KIND_FULL;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (fire) begin
                    if (!r_hold_valid || out_free) begin
                        if (r_hold_valid) begin
                            out_load           = 1'b1;
                            out_data.kind      = KIND_PIN_CHANGE;
                            out_data.out_pin   = r_hold_pin;
                            out_data.pin_level = r_hold_level;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_pin   = r_pin[r_idx];
                        n_hold_level = !r_on[r_idx];
                        n_occ[r_idx] = 1'b0;
                        advance      = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    if (r_hold_valid) begin
                        out_data.kind      = KIND_PIN_CHANGE;
                        out_data.out_pin   = r_hold_pin;
                        out_data.pin_level = r_hold_level;
                    end else begin
                        out_data.kind = KIND_IDLE;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (r_idx == SLOT_BITS'(SLOT_COUNT - 1)) begin
                n_state = ST_FLUSH;
            end else begin
                n_idx = r_idx + SLOT_BITS'(1);
            end
        end

        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out       = out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_occ        <= '0;
            r_idx        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_idx        <= n_idx;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_hold_pin   <= n_hold_pin;
        r_hold_level <= n_hold_level;
        r_out        <= n_out;
        if (wr_en) begin
            r_due[free_idx] <= i_cmd.time_val;
            r_pin[free_idx] <= i_cmd.pin;
            r_on[free_idx]  <= i_cmd.on;
        end
    end

    `ASSERT_NEXT(a_scan_forward, i_clk, i_rst_n, r_state == ST_SCAN,
        (r_state != ST_SCAN) || (r_idx >= $past(r_idx)), "scan index moved backward")
    `ASSERT_ALWAYS(a_hold_in_scan, i_clk, i_rst_n,
        !r_hold_valid || (r_state == ST_SCAN) || (r_state == ST_FLUSH),
        "held result outside a tick scan")
    `ASSERT_NEXT(a_occ_one_write, i_clk, i_rst_n, 1'b1,
        $countones(r_occ) <= $countones($past(r_occ)) + 1, "more than one slot filled")

endmodule

`default_nettype wire

[hw/rtl/timed_led_change_table.sv]
// ----------------------------------------------------------------------------
// timed_led_change_table
// Slot table of scheduled LED changes, driven by schedule and tick items.
// ----------------------------------------------------------------------------
// Input channel: push/full queue of items. A schedule item stores its due
// time, pin and state in the lowest free slot unless its due time is zero;
// a tick item carries the current time and fires every occupied slot whose
// due time is below it. Result channel: empty/pop queue. A schedule gives
// one result (accepted or table full); a tick gives one pin change per fired
// slot, in slot order, or one idle result; last marks the final result of
// each item. A two-entry command queue sits in front of the slot engine, so
// items are accepted while a result waits in the output register.
// A schedule result is loaded into the output register as the engine takes
// the item from the command queue. A tick is taken in the idle state, the
// scan state then compares the slots in slot order, and the flush state
// emits the last result; scan and flush may stall on a full output register.
// Reset clears all slots to free and drops queued items and results.
// When pop is held low the engine stalls on the output register and the
// command queue fills, then full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timed_led_change_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    input  wire tlct_pkg::t_item i_item,
    output logic                 full,
    output logic                 empty,
    input  wire logic            pop,
    output tlct_pkg::t_result    o_result
);
    import tlct_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_cmd_in;
    logic q_valid;
    t_cmd q_cmd_out;
    logic q_pop;

    tlct_front u_front (
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd_in)
    );

    tlct_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd_out)
    );

    tlct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd_out),
        .o_cmd_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
